// ----- hdl/lga_pkg.sv -----
// Package for the life grid automaton: grid sizes, field widths, action and
// register codes. Used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package lga_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);

  localparam int ACTION_W = 3;
  localparam int DIM_W    = 7;   // num_rows / num_cols register width
  localparam int GENS_W   = 16;
  localparam int GEN_W    = 32;
  localparam int CFG_IDX_W = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [MAX_COLS-1:0] row_bits_t;

  localparam action_t ACT_WRITE   = 3'd0;
  localparam action_t ACT_TOGGLE  = 3'd1;
  localparam action_t ACT_READ    = 3'd2;
  localparam action_t ACT_ADVANCE = 3'd3;
  localparam action_t ACT_CLEAR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

endpackage

// ----- hdl/lga_ifs.sv -----
// Valid/ready channel interfaces of the life grid automaton: request,
// response and configuration write. Depends on lga_pkg.
`timescale 1ns / 1ps

interface lga_cmd_if import lga_pkg::*; ();
  logic                  valid;
  logic                  ready;
  action_t               action;
  logic [ROW_AW-1:0]     row;
  logic [COL_AW-1:0]     col;
  logic                  alive;
  logic [GENS_W-1:0]     gen_count;

  modport source(output valid, action, row, col, alive, gen_count, input ready);
  modport sink(input valid, action, row, col, alive, gen_count, output ready);
endinterface

interface lga_rsp_if import lga_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cell_value;
  logic [GEN_W-1:0]  generation;

  modport source(output valid, cell_value, generation, input ready);
  modport sink(input valid, cell_value, generation, output ready);
endinterface

interface lga_cfg_if import lga_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [DIM_W-1:0]      data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/life_grid_automaton_unit.sv -----
// Life grid automaton top level: grid memory, row sweep engine and channels.
// Depends on lga_pkg and the interfaces in lga_ifs.sv.
`timescale 1ns / 1ps

// A 64 x 64 grid of one-bit cells, one row per memory word, evolving by the
// B3/S23 rule over the area set by num_rows / num_cols (no wraparound; cells
// outside that area keep their value and count as dead). Every request
// returns one response: the addressed cell after the action (0 when out of
// range) and the 32-bit generation counter. Cell requests (write, toggle,
// read, clear, unused codes) are accepted, then wait for the synchronous
// memory read, then modify, write back and load the response once the
// response register is free. An advance sweeps the grid one row per cycle
// through a three-row window; each generation reads the R rows in use plus
// one zero row before the sweep restarts, and the advance ends after
// gen_count generations or early once a generation changes nothing (the
// counter still gains the full gen_count).
// The grid is dead after reset through per-row valid bits, so no clearing
// pass is run. The response sits in an output register, so the next request
// is taken while an earlier response waits.
module life_grid_automaton_unit import lga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lga_cfg_if.sink    cfg,
  lga_cmd_if.sink    cmd,
  lga_rsp_if.source  rsp
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_CELL  = 2'd2;
  localparam logic [1:0] ST_ADV   = 2'd3;

  // Configuration and counters
  logic [DIM_W-1:0]   num_rows;
  logic [DIM_W-1:0]   num_cols;
  logic [DIM_W-1:0]   eff_rows;
  logic [DIM_W-1:0]   eff_cols;
  logic [GEN_W-1:0]   gen_count;
  logic [1:0]         state;

  // Latched request
  action_t            op_action;
  logic [ROW_AW-1:0]  op_row;
  logic [COL_AW-1:0]  op_col;
  logic               op_alive;

  // Sweep engine
  logic [GENS_W-1:0]  gen_left;
  logic [DIM_W-1:0]   rd_row;
  logic               p_valid;
  logic [DIM_W-1:0]   p_row;
  logic               p_live;
  logic               changed;
  row_bits_t          above_row;
  row_bits_t          center_row;

  // Grid memory
  row_bits_t          mem [MAX_ROWS];
  row_bits_t          mem_q;
  logic [MAX_ROWS-1:0] row_valid;
  logic [ROW_AW-1:0]  raddr;
  logic               we;
  logic [ROW_AW-1:0]  waddr;
  row_bits_t          wdata;

  // Response register
  logic               out_valid;
  logic               out_cell;
  logic [GEN_W-1:0]   out_gen;

  // Combinational helpers
  row_bits_t          col_mask;
  logic               issue;
  row_bits_t          below_raw;
  row_bits_t          sweep_row;
  logic               sweep_diff;
  logic               sweep_write;
  logic               gen_done;
  logic               slot_free;
  row_bits_t          cell_data;
  logic               in_range;
  logic               old_bit;
  logic               new_bit;
  logic               cell_write;
  row_bits_t          cell_row;
  logic               cmd_fire;
  logic               adv_go;

  // Next generation of one row from its masked neighbors.
  function automatic row_bits_t life_row(input row_bits_t up, input row_bits_t mid,
                                         input row_bits_t dn, input row_bits_t m);
    row_bits_t nb [8];
    row_bits_t s0;
    row_bits_t s1;
    row_bits_t s2;
    row_bits_t c0;
    row_bits_t c1;
    row_bits_t nxt;
    nb[0] = (up & m) << 1;
    nb[1] = up & m;
    nb[2] = (up & m) >> 1;
    nb[3] = (mid & m) << 1;
    nb[4] = (mid & m) >> 1;
    nb[5] = (dn & m) << 1;
    nb[6] = dn & m;
    nb[7] = (dn & m) >> 1;
    s0 = '0;
    s1 = '0;
    s2 = '0;
    for (int k = 0; k < 8; k++) begin
      c0 = s0 & nb[k];
      s0 = s0 ^ nb[k];
      c1 = s1 & c0;
      s1 = s1 ^ c0;
      s2 = s2 ^ c1;
    end
    // count is 3, or 2 with the cell alive
    nxt = ~s2 & s1 & (s0 | mid);
    return (nxt & m) | (mid & ~m);
  endfunction

  assign eff_rows = (num_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : num_rows;
  assign eff_cols = (num_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : num_cols;

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i] = DIM_W'(i) < eff_cols;
    end
  end

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign adv_go    = (cmd.action == ACT_ADVANCE) && (cmd.gen_count != '0) &&
                     (eff_rows != '0) && (eff_cols != '0);

  assign rsp.valid      = out_valid;
  assign rsp.cell_value = out_cell;
  assign rsp.generation = out_gen;
  assign slot_free      = !out_valid || rsp.ready;

  // Sweep: issue reads of rows 0..eff_rows (the last one is a zero row),
  // compute row p_row-1 when row p_row comes back.
  assign issue       = (state == ST_ADV) && (rd_row <= eff_rows);
  assign below_raw   = p_live ? mem_q : '0;
  assign sweep_row   = life_row(above_row, center_row, below_raw, col_mask);
  assign sweep_diff  = sweep_row != center_row;
  assign sweep_write = (state == ST_ADV) && p_valid && (p_row != '0);
  assign gen_done    = sweep_write && (p_row == eff_rows);

  // Cell access
  assign cell_data  = row_valid[op_row] ? mem_q : '0;
  assign in_range   = ({1'b0, op_row} < eff_rows) && ({1'b0, op_col} < eff_cols);
  assign old_bit    = cell_data[op_col];
  always_comb begin
    case (op_action)
      ACT_WRITE:  new_bit = op_alive;
      ACT_TOGGLE: new_bit = ~old_bit;
      default:    new_bit = old_bit;
    endcase
    cell_row         = cell_data;
    cell_row[op_col] = new_bit;
  end
  assign cell_write = (state == ST_CELL) && slot_free && in_range &&
                      ((op_action == ACT_WRITE) || (op_action == ACT_TOGGLE));

  // Memory port selection
  assign raddr = (state == ST_ADV) ? rd_row[ROW_AW-1:0] : op_row;
  always_comb begin
    if (sweep_write) begin
      we    = 1'b1;
      waddr = ROW_AW'(p_row - DIM_W'(1));
      wdata = sweep_row;
    end else begin
      we    = cell_write;
      waddr = op_row;
      wdata = cell_row;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // Window payload
  always_ff @(posedge clk) begin
    if ((state == ST_ADV) && p_valid) begin
      above_row  <= (p_row == '0) ? '0 : center_row;
      center_row <= below_raw;
    end
  end

  // Request fields
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_action <= cmd.action;
      op_row    <= cmd.row;
      op_col    <= cmd.col;
      op_alive  <= cmd.alive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= DIM_RESET;
      num_cols  <= DIM_RESET;
      gen_count <= '0;
      state     <= ST_IDLE;
      row_valid <= '0;
      gen_left  <= '0;
      rd_row    <= '0;
      p_valid   <= 1'b0;
      p_row     <= '0;
      p_live    <= 1'b0;
      changed   <= 1'b0;
      out_valid <= 1'b0;
      out_cell  <= 1'b0;
      out_gen   <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_NUM_ROWS: num_rows <= cfg.data;
          CFG_NUM_COLS: num_cols <= cfg.data;
          default: ;
        endcase
      end

      if (we) begin
        row_valid[waddr] <= 1'b1;
      end

      // drop the response once taken
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      // read pipeline tag
      p_valid <= issue;
      p_row   <= rd_row;
      p_live  <= (rd_row < eff_rows) && row_valid[rd_row[ROW_AW-1:0]];
      if (issue) begin
        rd_row <= rd_row + DIM_W'(1);
      end

      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            if (cmd.action == ACT_ADVANCE) begin
              gen_count <= gen_count + GEN_W'(cmd.gen_count);
            end else if (cmd.action == ACT_CLEAR) begin
              gen_count <= '0;
            end
            if (adv_go) begin
              gen_left <= cmd.gen_count;
              rd_row   <= '0;
              changed  <= 1'b0;
              state    <= ST_ADV;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_CELL;
        end
        ST_CELL: begin
          // hold until the response register is free
          if (slot_free) begin
            out_valid <= 1'b1;
            out_cell  <= in_range & new_bit;
            out_gen   <= gen_count;
            state     <= ST_IDLE;
          end
        end
        ST_ADV: begin
          if (sweep_write) begin
            changed <= changed | sweep_diff;
          end
          if (gen_done) begin
            if ((changed || sweep_diff) && (gen_left != GENS_W'(1))) begin
              // advance to the next generation
              gen_left <= gen_left - GENS_W'(1);
              rd_row   <= '0;
              changed  <= 1'b0;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
